// ===== rtl/core/mfb_pkg.sv =====
// ----------------------------------------------------------------------------
// mfb_pkg
// shared types, constants and the key usage table of the frame builder
// ----------------------------------------------------------------------------
`default_nettype none

package mfb_pkg;

    localparam int SLOTS_DEF      = 16;
    localparam int FRAME_ROWS_DEF = 16;
    localparam int MAX_OUT        = 32;
    localparam int CNT_W          = 6;
    localparam int SLOT_W         = 4;
    localparam int TS_W           = 63;
    localparam int S_TDATA_W      = 104;
    localparam int M_TDATA_W      = 176;
    localparam int META_W         = 14;
    localparam int POS_W          = 64;

    localparam logic [31:0] LIFT_ID = 32'hFFFF_FFFF;

    localparam int FL_ACTIVE  = 0;
    localparam int FL_LIFTING = 1;
    localparam int FL_CHANGED = 2;
    localparam int FL_PLACED  = 3;

    typedef enum logic [2:0] {
        FN_SLOT   = 3'd0,
        FN_TRACK  = 3'd1,
        FN_POS_X  = 3'd2,
        FN_POS_Y  = 3'd3,
        FN_SYNC   = 3'd4,
        FN_KEY    = 3'd5,
        FN_FLUSH  = 3'd6,
        FN_IGNORE = 3'd7
    } t_func;

    typedef struct packed {
        logic              accept;
        logic              walk;
        logic [SLOT_W-1:0] walk_idx;
        logic              decide;
        logic              rd_en;
        logic [CNT_W-1:0]  row_idx;
        logic              emit;
        logic              last;
    } t_cmd;

    typedef struct packed {
        logic             dirty;
        logic [CNT_W-1:0] total_next;
    } t_sts;

    function automatic logic [7:0] map_usage(input logic [7:0] code);
        logic [7:0] u;
        case (code)
            8'd1: u = 8'h29;   8'd2: u = 8'h1E;   8'd3: u = 8'h1F;   8'd4: u = 8'h20;
            8'd5: u = 8'h21;   8'd6: u = 8'h22;   8'd7: u = 8'h23;   8'd8: u = 8'h24;
            8'd9: u = 8'h25;   8'd10: u = 8'h26;  8'd11: u = 8'h27;  8'd12: u = 8'h2D;
            8'd13: u = 8'h2E;  8'd14: u = 8'h2A;  8'd15: u = 8'h2B;  8'd16: u = 8'h14;
            8'd17: u = 8'h1A;  8'd18: u = 8'h08;  8'd19: u = 8'h15;  8'd20: u = 8'h17;
            8'd21: u = 8'h1C;  8'd22: u = 8'h18;  8'd23: u = 8'h0C;  8'd24: u = 8'h12;
            8'd25: u = 8'h13;  8'd26: u = 8'h2F;  8'd27: u = 8'h30;  8'd28: u = 8'h28;
            8'd29: u = 8'hE0;  8'd30: u = 8'h04;  8'd31: u = 8'h16;  8'd32: u = 8'h07;
            8'd33: u = 8'h09;  8'd34: u = 8'h0A;  8'd35: u = 8'h0B;  8'd36: u = 8'h0D;
            8'd37: u = 8'h0E;  8'd38: u = 8'h0F;  8'd39: u = 8'h33;  8'd40: u = 8'h34;
            8'd41: u = 8'h35;  8'd42: u = 8'hE1;  8'd43: u = 8'h31;  8'd44: u = 8'h1D;
            8'd45: u = 8'h1B;  8'd46: u = 8'h06;  8'd47: u = 8'h19;  8'd48: u = 8'h05;
            8'd49: u = 8'h11;  8'd50: u = 8'h10;  8'd51: u = 8'h36;  8'd52: u = 8'h37;
            8'd53: u = 8'h38;  8'd54: u = 8'hE5;  8'd55: u = 8'h55;  8'd56: u = 8'hE2;
            8'd57: u = 8'h2C;  8'd58: u = 8'h39;  8'd59: u = 8'h3A;  8'd60: u = 8'h3B;
            8'd61: u = 8'h3C;  8'd62: u = 8'h3D;  8'd63: u = 8'h3E;  8'd64: u = 8'h3F;
            8'd65: u = 8'h40;  8'd66: u = 8'h41;  8'd67: u = 8'h42;  8'd68: u = 8'h43;
            8'd69: u = 8'h53;  8'd70: u = 8'h47;  8'd71: u = 8'h5F;  8'd72: u = 8'h60;
            8'd73: u = 8'h61;  8'd74: u = 8'h56;  8'd75: u = 8'h5C;  8'd76: u = 8'h5D;
            8'd77: u = 8'h5E;  8'd78: u = 8'h57;  8'd79: u = 8'h59;  8'd80: u = 8'h5A;
            8'd81: u = 8'h5B;  8'd82: u = 8'h62;  8'd83: u = 8'h63;  8'd87: u = 8'h44;
            8'd88: u = 8'h45;  8'd96: u = 8'h58;  8'd97: u = 8'hE4;  8'd98: u = 8'h54;
            8'd99: u = 8'h46;  8'd100: u = 8'hE6; 8'd102: u = 8'h4A; 8'd103: u = 8'h52;
            8'd104: u = 8'h4B; 8'd105: u = 8'h50; 8'd106: u = 8'h4F; 8'd107: u = 8'h4D;
            8'd108: u = 8'h51; 8'd109: u = 8'h4E; 8'd110: u = 8'h49; 8'd111: u = 8'h4C;
            8'd119: u = 8'h48; 8'd125: u = 8'hE3; 8'd126: u = 8'hE7; 8'd127: u = 8'h65;
            8'd183: u = 8'h68; 8'd184: u = 8'h69; 8'd185: u = 8'h6A; 8'd186: u = 8'h6B;
            8'd187: u = 8'h6C; 8'd188: u = 8'h6D; 8'd189: u = 8'h6E; 8'd190: u = 8'h6F;
            8'd191: u = 8'h70;
            default: u = 8'h00;
        endcase
        return u;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/mfb_ctrl.sv =====
// ----------------------------------------------------------------------------
// mfb_ctrl
// sequencer: slot walk on sync, frame close, row read and output handshake
// ----------------------------------------------------------------------------
`default_nettype none

module mfb_ctrl
    import mfb_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [2:0] i_func,
    input  wire logic       i_out_ready,
    input  wire t_sts       i_sts,
    output t_cmd            o_cmd
);

    localparam int SIDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_WALK   = 5'b00010,
        ST_DECIDE = 5'b00100,
        ST_READ   = 5'b01000,
        ST_EMIT   = 5'b10000
    } t_state;

    t_state             r_state, n_state;
    logic [SIDX_W-1:0]  r_widx, n_widx;
    logic [CNT_W-1:0]   r_total, n_total;
    logic [CNT_W-1:0]   r_row, n_row;
    logic               w_last;

    assign w_last = (r_row == r_total - CNT_W'(1));

    always_comb begin
        n_state = r_state;
        n_widx  = r_widx;
        n_total = r_total;
        n_row   = r_row;
        o_in_ready = 1'b0;
        o_cmd = '0;
        o_cmd.walk_idx = SLOT_W'(r_widx);
        o_cmd.row_idx  = r_row;
        o_cmd.last     = w_last;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.accept = i_in_valid;
                n_widx = '0;
                if (i_in_valid) begin
                    if (i_func == FN_SYNC) begin
                        n_state = i_sts.dirty ? ST_WALK : ST_DECIDE;
                    end else if (i_func == FN_FLUSH) begin
                        n_state = ST_DECIDE;
                    end
                end
            end
            ST_WALK: begin
                o_cmd.walk = 1'b1;
                if (r_widx == SIDX_W'(SLOTS - 1)) begin
                    n_state = ST_DECIDE;
                end else begin
                    n_widx = r_widx + SIDX_W'(1);
                end
            end
            ST_DECIDE: begin
                o_cmd.decide = 1'b1;
                n_total = i_sts.total_next;
                n_row   = '0;
                n_state = (i_sts.total_next == '0) ? ST_IDLE : ST_READ;
            end
            ST_READ: begin
                o_cmd.rd_en = 1'b1;
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                o_cmd.emit = 1'b1;
                if (i_out_ready) begin
                    if (w_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_row   = r_row + CNT_W'(1);
                        n_state = ST_READ;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_widx  <= '0;
            r_total <= '0;
            r_row   <= '0;
        end else begin
            r_state <= n_state;
            r_widx  <= n_widx;
            r_total <= n_total;
            r_row   <= n_row;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/mfb_dp.sv =====
// ----------------------------------------------------------------------------
// mfb_dp
// slot state, two-bank row memory, frame counters and output row assembly
// ----------------------------------------------------------------------------
`default_nettype none

module mfb_dp
    import mfb_pkg::*;
#(
    parameter int SLOTS      = SLOTS_DEF,
    parameter int FRAME_ROWS = FRAME_ROWS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_cmd                 i_cmd,
    input  wire logic [2:0]           i_func,
    input  wire logic [31:0]          i_value,
    input  wire logic [7:0]           i_code,
    input  wire logic [TS_W-1:0]      i_ts,
    output t_sts                      o_sts,
    output logic [M_TDATA_W-1:0]      o_tdata,
    output logic                      o_tuser
);

    localparam int SIDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int DEPTH  = 2 * FRAME_ROWS;
    localparam int AW     = $clog2(DEPTH);

    logic [3:0]          r_flags [SLOTS];
    logic [31:0]         r_x     [SLOTS];
    logic [31:0]         r_y     [SLOTS];
    logic [SIDX_W-1:0]   r_cur;
    logic                r_dirty;
    logic [CNT_W-1:0]    r_fc, r_pc;
    logic                r_bank;
    logic [TS_W-1:0]     r_pt;
    logic                r_pt_ok;
    logic [31:0]         r_unmapped;
    logic                r_drop;
    logic [2:0]          r_func;
    logic [TS_W-1:0]     r_ts;
    logic [CNT_W-1:0]    r_em_pc;
    logic                r_em_pb, r_em_fb;
    logic [TS_W-1:0]     r_wait;
    logic                r_is_sync;

    logic [META_W-1:0]   r_mem_meta [DEPTH];
    logic [POS_W-1:0]    r_mem_pos  [DEPTH];
    logic [META_W-1:0]   r_rd_meta;
    logic [POS_W-1:0]    r_rd_pos;

    // working slot and its updated flags
    logic [SIDX_W-1:0]   w_sidx;
    logic [3:0]          w_f, w_fn;
    logic                w_set_dirty;
    logic                w_stage;
    logic [META_W-1:0]   w_meta;
    logic [POS_W-1:0]    w_pos;
    logic                w_full;
    logic [AW-1:0]       w_waddr, w_raddr;
    logic [7:0]          w_usage;
    logic [CNT_W:0]      w_sum;
    logic [CNT_W-1:0]    w_total;
    logic [TS_W-1:0]     w_wait;
    logic [TS_W-1:0]     w_wait_out;

    assign w_sidx  = i_cmd.walk ? i_cmd.walk_idx[SIDX_W-1:0] : r_cur;
    assign w_f     = r_flags[w_sidx];
    assign w_usage = map_usage(i_code);
    assign w_full  = (r_fc >= CNT_W'(FRAME_ROWS));
    assign w_waddr = (r_bank ? AW'(FRAME_ROWS) : AW'(0)) + AW'(r_fc);
    assign w_sum   = {1'b0, r_pc} + {1'b0, r_fc};

    always_comb begin
        w_fn        = w_f;
        w_set_dirty = 1'b0;
        w_stage     = 1'b0;
        w_meta      = '0;
        w_pos       = '0;
        if (i_cmd.walk) begin
            if (w_f[FL_CHANGED]) begin
                w_fn[FL_CHANGED] = 1'b0;
                w_pos = {r_y[w_sidx], r_x[w_sidx]};
                if (w_f[FL_LIFTING]) begin
                    w_fn[FL_LIFTING] = 1'b0;
                    w_fn[FL_ACTIVE]  = 1'b0;
                    if (w_f[FL_PLACED]) begin
                        w_fn[FL_PLACED] = 1'b0;
                        w_stage = 1'b1;
                        w_meta  = {8'h00, 1'b0, SLOT_W'(w_sidx), 1'b0};
                    end
                end else if (w_f[FL_ACTIVE]) begin
                    w_fn[FL_PLACED] = 1'b1;
                    w_stage = 1'b1;
                    w_meta  = {8'h00, 1'b1, SLOT_W'(w_sidx), 1'b0};
                end
            end
        end else if (i_cmd.accept) begin
            case (i_func)
                FN_TRACK: begin
                    if (i_value == LIFT_ID) begin
                        if (w_f[FL_ACTIVE]) begin
                            w_fn[FL_LIFTING] = 1'b1;
                            w_fn[FL_CHANGED] = 1'b1;
                            w_set_dirty = 1'b1;
                        end
                    end else if (!w_f[FL_ACTIVE]) begin
                        w_fn[FL_LIFTING] = 1'b0;
                        w_fn[FL_ACTIVE]  = 1'b1;
                        w_fn[FL_CHANGED] = 1'b1;
                        w_set_dirty = 1'b1;
                    end
                end
                FN_POS_X, FN_POS_Y: begin
                    if (w_f[FL_ACTIVE]) begin
                        w_fn[FL_CHANGED] = 1'b1;
                        w_set_dirty = 1'b1;
                    end
                end
                FN_KEY: begin
                    if (i_value <= 32'd1 && w_usage != 8'h00) begin
                        w_stage = 1'b1;
                        w_meta  = {w_usage, i_value[0], SLOT_W'(0), 1'b1};
                    end
                end
                default: w_stage = 1'b0;
            endcase
        end
    end

    // frame close and flush bookkeeping
    always_comb begin
        w_total = '0;
        w_wait  = '0;
        if (r_pt_ok && r_ts >= r_pt) begin
            w_wait = r_ts - r_pt;
        end
        if (r_func == FN_SYNC) begin
            if (r_fc != '0) begin
                w_total = r_pc;
            end
        end else if (w_sum > (CNT_W + 1)'(MAX_OUT)) begin
            w_total = CNT_W'(MAX_OUT);
        end else begin
            w_total = w_sum[CNT_W-1:0];
        end
    end

    assign o_sts.dirty      = r_dirty;
    assign o_sts.total_next = w_total;

    always_comb begin
        if (i_cmd.row_idx < r_em_pc) begin
            w_raddr = (r_em_pb ? AW'(FRAME_ROWS) : AW'(0)) + AW'(i_cmd.row_idx);
        end else begin
            w_raddr = (r_em_fb ? AW'(FRAME_ROWS) : AW'(0)) + AW'(i_cmd.row_idx - r_em_pc);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_stage && !w_full) begin
            r_mem_meta[w_waddr] <= w_meta;
            r_mem_pos[w_waddr]  <= w_pos;
        end
        if (i_cmd.rd_en) begin
            r_rd_meta <= r_mem_meta[w_raddr];
            r_rd_pos  <= r_mem_pos[w_raddr];
        end
        if (i_cmd.accept) begin
            r_func <= i_func;
            r_ts   <= i_ts;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++) begin
                r_flags[i] <= '0;
                r_x[i]     <= '0;
                r_y[i]     <= '0;
            end
            r_cur      <= '0;
            r_dirty    <= 1'b0;
            r_fc       <= '0;
            r_pc       <= '0;
            r_bank     <= 1'b0;
            r_pt       <= '0;
            r_pt_ok    <= 1'b0;
            r_unmapped <= '0;
            r_drop     <= 1'b0;
            r_em_pc    <= '0;
            r_em_pb    <= 1'b0;
            r_em_fb    <= 1'b0;
            r_wait     <= '0;
            r_is_sync  <= 1'b0;
        end else begin
            r_flags[w_sidx] <= w_fn;
            if (w_set_dirty) begin
                r_dirty <= 1'b1;
            end
            if (w_stage) begin
                if (w_full) begin
                    r_drop <= 1'b1;
                end else begin
                    r_fc <= r_fc + CNT_W'(1);
                end
            end
            if (i_cmd.accept) begin
                case (i_func)
                    FN_SLOT: begin
                        if (i_value < 32'(SLOTS)) begin
                            r_cur <= i_value[SIDX_W-1:0];
                        end
                    end
                    FN_POS_X: r_x[r_cur] <= i_value;
                    FN_POS_Y: r_y[r_cur] <= i_value;
                    FN_KEY: begin
                        if (i_value <= 32'd1 && w_usage == 8'h00) begin
                            r_unmapped <= r_unmapped + 32'd1;
                        end
                    end
                    default: r_cur <= r_cur;
                endcase
            end
            if (i_cmd.decide) begin
                r_em_pc   <= r_pc;
                r_em_pb   <= ~r_bank;
                r_em_fb   <= r_bank;
                r_is_sync <= (r_func == FN_SYNC);
                r_wait    <= w_wait;
                if (r_func == FN_SYNC) begin
                    r_dirty <= 1'b0;
                    if (r_fc != '0) begin
                        r_bank  <= ~r_bank;
                        r_pc    <= r_fc;
                        r_fc    <= '0;
                        r_pt    <= r_ts;
                        r_pt_ok <= 1'b1;
                    end
                end else begin
                    if (w_sum > (CNT_W + 1)'(MAX_OUT)) begin
                        r_drop <= 1'b1;
                    end
                    r_pc <= '0;
                    r_fc <= '0;
                end
            end
        end
    end

    assign w_wait_out = (i_cmd.last && r_is_sync) ? r_wait : '0;

    // slot, pressed, x, y, usage, wait, unmapped, dropped
    assign o_tdata = {3'b000, r_drop, r_unmapped, w_wait_out, r_rd_meta[13:6],
                      r_rd_pos[63:32], r_rd_pos[31:0], r_rd_meta[5], r_rd_meta[4:1]};
    assign o_tuser = r_rd_meta[0];

endmodule

`default_nettype wire

// ===== rtl/core/multitouch_frame_builder.sv =====
// ----------------------------------------------------------------------------
// multitouch_frame_builder
// multitouch slot tracker that turns decoded events into touch and key rows
// ----------------------------------------------------------------------------
// channel | dir | tdata                                   | tuser    | tlast
// s       | in  | event_value, key_code, event_time       | func     | -
// m       | out | slot..rows_dropped (see port)           | row_kind | last_row
//
// simple events keep the sequencer idle; after a sync is taken, the slots are walked
// one per cycle only when some slot changed, then the frame is closed and each row
// is a memory read, then a beat
// flush closes the frame, then reads and emits each row, at most 32 rows
// reset is synchronous, active low; the row memory needs no clearing
// a stalled output holds the sequencer; no input is taken until the last row
// ----------------------------------------------------------------------------
`default_nettype none

module multitouch_frame_builder
    import mfb_pkg::*;
#(
    parameter int SLOTS      = SLOTS_DEF,
    parameter int FRAME_ROWS = FRAME_ROWS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_s_tvalid,
    output logic                       o_s_tready,
    // event_value[31:0], key_code[39:32], event_time[102:40]
    input  wire logic [S_TDATA_W-1:0]  i_s_tdata,
    // func[2:0]
    input  wire logic [2:0]            i_s_tuser,
    output logic                       o_m_tvalid,
    input  wire logic                  i_m_tready,
    // slot_index[3:0], pressed[4], pos_x[36:5], pos_y[68:37], usage_code[76:69],
    // wait_ns[139:77], unmapped_count[171:140], rows_dropped[172]
    output logic [M_TDATA_W-1:0]       o_m_tdata,
    // row_kind[0]
    output logic                       o_m_tuser,
    output logic                       o_m_tlast
);

    t_cmd w_cmd;
    t_sts w_sts;

    mfb_ctrl #(
        .SLOTS (SLOTS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_tvalid),
        .o_in_ready  (o_s_tready),
        .i_func      (i_s_tuser),
        .i_out_ready (i_m_tready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    mfb_dp #(
        .SLOTS      (SLOTS),
        .FRAME_ROWS (FRAME_ROWS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_func  (i_s_tuser),
        .i_value (i_s_tdata[31:0]),
        .i_code  (i_s_tdata[39:32]),
        .i_ts    (i_s_tdata[102:40]),
        .o_sts   (w_sts),
        .o_tdata (o_m_tdata),
        .o_tuser (o_m_tuser)
    );

    assign o_m_tvalid = w_cmd.emit;
    assign o_m_tlast  = w_cmd.emit & w_cmd.last;

endmodule

`default_nettype wire

// ===== rtl/core/mfb_checker.sv =====
// ----------------------------------------------------------------------------
// mfb_checker
// port-level checks of the frame builder, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module mfb_checker
    import mfb_pkg::*;
(
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 i_s_tvalid,
    input wire logic                 o_s_tready,
    input wire logic                 o_m_tvalid,
    input wire logic                 i_m_tready,
    input wire logic [M_TDATA_W-1:0] o_m_tdata,
    input wire logic                 o_m_tuser,
    input wire logic                 o_m_tlast
);

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_s_tready && o_m_tvalid))
        else $error("input taken while a row is offered");

    a_more_rows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && i_m_tready && !o_m_tlast) |=> !o_s_tready)
        else $error("input taken before the last row");

    a_read_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_m_tvalid)
        else $error("row offered without a memory read");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)
            && $stable(o_m_tuser) && $stable(o_m_tlast)))
        else $error("stalled beat changed");

    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_tvalid)
        else $error("row offered after reset");

endmodule

bind multitouch_frame_builder mfb_checker u_mfb_checker (.*);

`default_nettype wire
